### sv/bsc_pkg.sv
package bsc_pkg;

  // Fixed field widths of the stream payloads
  localparam int FIELD_W     = 48;
  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 3;

  localparam int POS_WIDTH_DEF   = 48;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  // Packed widths of the stream ports
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 168;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_POS_ONE = 3'd0,
    REG_START_POS_TWO = 3'd1,
    REG_COUNT_LIMIT   = 3'd2,
    REG_SILENT_MODE   = 3'd3,
    REG_REPORT_ALL    = 3'd4,
    REG_COUNT_LINES   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_SAME       = 3'd0,
    ST_ONE_LONGER = 3'd1,
    ST_TWO_LONGER = 3'd2,
    ST_DIFFER     = 3'd3,
    ST_ERROR_ONE  = 3'd4,
    ST_ERROR_TWO  = 3'd5
  } status_t;

  typedef enum logic {
    KIND_MISMATCH = 1'b0,
    KIND_FINAL    = 1'b1
  } record_kind_t;

  // One queue entry: the records caused by one input transaction
  typedef struct packed {
    logic                has_mismatch;
    logic                has_final;
    status_t             final_status;
    logic [FIELD_W-1:0]  mm_pos_one;
    logic [FIELD_W-1:0]  mm_pos_two;
    logic [FIELD_W-1:0]  fin_pos_one;
    logic [FIELD_W-1:0]  fin_pos_two;
    logic [FIELD_W-1:0]  line_number;
    logic [BYTE_W-1:0]   mismatch_one;
    logic [BYTE_W-1:0]   mismatch_two;
  } entry_t;

endpackage

### sv/bsc_front.sv
module bsc_front
  import bsc_pkg::*;
#(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]     cfg_data,
  // input stream
  input  logic                   in_accept,
  input  logic [BYTE_W-1:0]      byte_one,
  input  logic [BYTE_W-1:0]      byte_two,
  input  logic                   has_one,
  input  logic                   has_two,
  input  logic                   error_one,
  input  logic                   error_two,
  // queue write side
  output logic                   push,
  output entry_t                 entry
);

  localparam int CMP_W = (POS_WIDTH > FIELD_W) ? POS_WIDTH : FIELD_W;

  // Configuration registers
  logic [FIELD_W-1:0] start_pos_one;
  logic [FIELD_W-1:0] start_pos_two;
  logic [FIELD_W-1:0] count_limit;
  logic               silent_mode;
  logic               report_all;
  logic               count_lines;

  // Comparison state
  logic                 finished, finished_next;
  logic                 differ, differ_next;
  logic [POS_WIDTH-1:0] offset_one, offset_one_next;
  logic [POS_WIDTH-1:0] offset_two, offset_two_next;
  logic [POS_WIDTH-1:0] pairs_done, pairs_done_next;
  logic [POS_WIDTH-1:0] newline_total, newline_total_next;

  logic                 cfg_hit;
  logic                 limit_now;
  logic                 limit_after;
  logic                 mismatch;
  logic [POS_WIDTH-1:0] inc_one, inc_two, inc_pairs, inc_newline;
  status_t              code_status;

  function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Decode register index
  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_START_POS_ONE, REG_START_POS_TWO, REG_COUNT_LIMIT,
      REG_SILENT_MODE, REG_REPORT_ALL, REG_COUNT_LINES: cfg_hit = cfg_valid;
      default: cfg_hit = 1'b0;
    endcase
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos_one <= '0;
      start_pos_two <= '0;
      count_limit   <= '0;
      silent_mode   <= 1'b0;
      report_all    <= 1'b0;
      count_lines   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_POS_ONE: start_pos_one <= cfg_data;
        REG_START_POS_TWO: start_pos_two <= cfg_data;
        REG_COUNT_LIMIT:   count_limit   <= cfg_data;
        REG_SILENT_MODE:   silent_mode   <= cfg_data[0];
        REG_REPORT_ALL:    report_all    <= cfg_data[0];
        REG_COUNT_LINES:   count_lines   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign inc_one     = sat_inc(offset_one);
  assign inc_two     = sat_inc(offset_two);
  assign inc_pairs   = sat_inc(pairs_done);
  assign inc_newline = sat_inc(newline_total);
  assign mismatch    = (byte_one != byte_two);
  assign code_status = differ ? ST_DIFFER : ST_SAME;

  assign limit_now   = (count_limit != '0) &&
                       (CMP_W'(pairs_done) >= CMP_W'(count_limit));
  assign limit_after = (count_limit != '0) &&
                       (CMP_W'(inc_pairs) >= CMP_W'(count_limit));

  // Classify the transaction and build its queue entry
  always_comb begin
    finished_next      = finished;
    differ_next        = differ;
    offset_one_next    = offset_one;
    offset_two_next    = offset_two;
    pairs_done_next    = pairs_done;
    newline_total_next = newline_total;

    entry              = '0;
    entry.final_status = code_status;
    entry.fin_pos_one  = FIELD_W'(offset_one);
    entry.fin_pos_two  = FIELD_W'(offset_two);
    entry.line_number  = count_lines ? FIELD_W'(newline_total) : '0;

    if (in_accept && !finished) begin
      if (limit_now) begin
        entry.has_final = 1'b1;
      end else if (error_one) begin
        entry.has_final    = 1'b1;
        entry.final_status = ST_ERROR_ONE;
      end else if (error_two) begin
        entry.has_final    = 1'b1;
        entry.final_status = ST_ERROR_TWO;
      end else if (!has_one) begin
        entry.has_final = 1'b1;
        if (has_two && !differ) entry.final_status = ST_TWO_LONGER;
      end else if (!has_two) begin
        entry.has_final = 1'b1;
        if (!differ) entry.final_status = ST_ONE_LONGER;
      end else begin
        // Compare one pair and advance positions
        if (!mismatch && count_lines && byte_one == NEWLINE_BYTE) begin
          newline_total_next = inc_newline;
        end
        differ_next        = differ | mismatch;
        offset_one_next    = inc_one;
        offset_two_next    = inc_two;
        pairs_done_next    = inc_pairs;

        entry.has_mismatch = mismatch && !silent_mode;
        entry.mm_pos_one   = FIELD_W'(offset_one);
        entry.mm_pos_two   = FIELD_W'(offset_two);
        entry.mismatch_one = byte_one;
        entry.mismatch_two = byte_two;
        entry.fin_pos_one  = FIELD_W'(inc_one);
        entry.fin_pos_two  = FIELD_W'(inc_two);
        entry.line_number  = count_lines ? FIELD_W'(newline_total_next) : '0;
        entry.final_status = differ_next ? ST_DIFFER : ST_SAME;

        if (mismatch && (silent_mode || !report_all)) begin
          entry.has_final    = 1'b1;
          entry.final_status = ST_DIFFER;
        end else if (limit_after) begin
          entry.has_final = 1'b1;
        end
      end
      if (entry.has_final) finished_next = 1'b1;
    end
  end

  assign push = entry.has_mismatch || entry.has_final;

  // Advance comparison state; any register write restarts it
  always_ff @(posedge clk) begin
    if (rst) begin
      finished      <= 1'b0;
      differ        <= 1'b0;
      offset_one    <= '0;
      offset_two    <= '0;
      pairs_done    <= '0;
      newline_total <= '0;
    end else if (cfg_hit) begin
      finished      <= 1'b0;
      differ        <= 1'b0;
      pairs_done    <= '0;
      newline_total <= '0;
      offset_one    <= POS_WIDTH'(start_pos_one);
      offset_two    <= POS_WIDTH'(start_pos_two);
      case (cfg_reg_t'(cfg_index))
        REG_START_POS_ONE: offset_one <= POS_WIDTH'(cfg_data);
        REG_START_POS_TWO: offset_two <= POS_WIDTH'(cfg_data);
        default: ;
      endcase
    end else begin
      finished      <= finished_next;
      differ        <= differ_next;
      offset_one    <= offset_one_next;
      offset_two    <= offset_two_next;
      pairs_done    <= pairs_done_next;
      newline_total <= newline_total_next;
    end
  end

endmodule

### sv/bsc_queue.sv
module bsc_queue
  import bsc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/bsc_back.sv
module bsc_back
  import bsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // queue read side
  input  logic                  empty,
  input  entry_t                head,
  output logic                  pop,
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  logic               load;
  logic               emit_mismatch;
  logic               mm_sent;
  record_kind_t       kind;
  status_t            status;
  logic [FIELD_W-1:0] position_one, position_two, line_number;
  logic [BYTE_W-1:0]  mismatch_one, mismatch_two;

  assign load          = !m_axis_tvalid || m_axis_tready;
  assign emit_mismatch = head.has_mismatch && !mm_sent;
  // Keep the entry while its final record is still to follow
  assign pop           = load && !empty && !(emit_mismatch && head.has_final);

  // Load the output register one record at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      mm_sent       <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= !empty;
      if (!empty) mm_sent <= emit_mismatch && head.has_final;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      line_number <= head.line_number;
      if (emit_mismatch) begin
        kind         <= KIND_MISMATCH;
        status       <= ST_DIFFER;
        position_one <= head.mm_pos_one;
        position_two <= head.mm_pos_two;
        mismatch_one <= head.mismatch_one;
        mismatch_two <= head.mismatch_two;
        m_axis_tlast <= 1'b0;
      end else begin
        kind         <= KIND_FINAL;
        status       <= head.final_status;
        position_one <= head.fin_pos_one;
        position_two <= head.fin_pos_two;
        mismatch_one <= '0;
        mismatch_two <= '0;
        m_axis_tlast <= 1'b1;
      end
    end
  end

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {5'b0, mismatch_two, mismatch_one, line_number,
                         position_two, position_one, status};

endmodule

### sv/byte_stream_comparator.sv
// A transaction is classified by the front, held as a queue entry and loaded into
// the output register to go out on m_axis. Throughput: one input transaction per
// cycle while the queue is not full; one record per cycle on the output while
// m_axis_tready is high; a final transaction with a difference gives two records.
// Reset (rst, synchronous) clears the configuration registers, the queue and the
// comparison state; m_axis_tvalid is low until the first record is loaded.
module byte_stream_comparator
  import bsc_pkg::*;
#(
  parameter int POS_WIDTH   = POS_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]     cfg_data,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // byte_one, byte_two
  input  logic [IN_USER_W-1:0]   s_axis_tuser,  // has_one, has_two, error_one, error_two
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status, position_one, position_two, line_number, mismatch_one, mismatch_two, zero pad
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                   m_axis_tuser,  // record_kind
  output logic                   m_axis_tlast
);

  logic   push, pop, full, empty, in_accept;
  entry_t entry, head;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  bsc_front #(
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_accept(in_accept),
    .byte_one (s_axis_tdata[7:0]),
    .byte_two (s_axis_tdata[15:8]),
    .has_one  (s_axis_tuser[0]),
    .has_two  (s_axis_tuser[1]),
    .error_one(s_axis_tuser[2]),
    .error_two(s_axis_tuser[3]),
    .push     (push),
    .entry    (entry)
  );

  bsc_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(entry),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  bsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

### bench/tb_byte_stream_comparator.sv
module tb_byte_stream_comparator
  import bsc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FIELD_W-1:0] POS_MAX = '1;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS  = 320;
  localparam int MAX_REPORTS   = 40;

  // One byte pair offered on the input stream
  typedef struct packed {
    logic [BYTE_W-1:0] one;
    logic [BYTE_W-1:0] two;
    logic              has_one;
    logic              has_two;
    logic              err_one;
    logic              err_two;
  } pair_t;

  // One record on the output stream
  typedef struct packed {
    record_kind_t       kind;
    status_t            status;
    logic [FIELD_W-1:0] pos_one;
    logic [FIELD_W-1:0] pos_two;
    logic [FIELD_W-1:0] line;
    logic [BYTE_W-1:0]  byte_one;
    logic [BYTE_W-1:0]  byte_two;
    logic               last;
  } record_t;

  typedef struct packed {
    logic [FIELD_W-1:0] start_one;
    logic [FIELD_W-1:0] start_two;
    logic [FIELD_W-1:0] limit;
    logic               silent;
    logic               report_all;
    logic               count_lines;
  } cfg_set_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0]     cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [IN_USER_W-1:0]   s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  // Comparator state as the bench sees it
  cfg_set_t           regs;
  logic               cmp_done;
  status_t            run_code;
  logic [FIELD_W-1:0] at_one;
  logic [FIELD_W-1:0] at_two;
  logic [FIELD_W-1:0] pairs;
  logic [FIELD_W-1:0] newlines;

  record_t pending_records[$];

  int send_gap_max = 5;
  int recv_gap_max = 5;
  int recv_hold = 0;
  int error_count = 0;
  int compared_items = 0;
  int ignored_items = 0;
  int comparisons = 1;
  int mismatch_records = 0;
  int final_records = 0;

  byte_stream_comparator u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Comparator prediction
  // ---------------------------------------------------------------------------

  function automatic logic [FIELD_W-1:0] bump(logic [FIELD_W-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void restart_comparison();
    cmp_done = 1'b0;
    run_code = ST_SAME;
    at_one   = regs.start_one;
    at_two   = regs.start_two;
    pairs    = '0;
    newlines = '0;
  endfunction

  function automatic bit limit_hit();
    return regs.limit != '0 && pairs >= regs.limit;
  endfunction

  function automatic void push_record(record_kind_t kind, status_t st,
                                      logic [BYTE_W-1:0] b1, logic [BYTE_W-1:0] b2);
    record_t r;
    r.kind     = kind;
    r.status   = st;
    r.pos_one  = at_one;
    r.pos_two  = at_two;
    r.line     = regs.count_lines ? newlines : '0;
    r.byte_one = b1;
    r.byte_two = b2;
    r.last     = (kind == KIND_FINAL);
    pending_records.push_back(r);
  endfunction

  function automatic void close_comparison(status_t st);
    cmp_done = 1'b1;
    push_record(KIND_FINAL, st, '0, '0);
  endfunction

  // Work out the records that one accepted pair causes
  function automatic void step_comparison(pair_t p);
    if (cmp_done) begin
      ignored_items++;
      return;
    end
    compared_items++;
    if (limit_hit()) begin
      close_comparison(run_code);
      return;
    end
    // errors win over data; the first stream's error wins over the second's
    if (p.err_one) begin
      close_comparison(ST_ERROR_ONE);
      return;
    end
    if (p.err_two) begin
      close_comparison(ST_ERROR_TWO);
      return;
    end
    if (!p.has_one) begin
      close_comparison((p.has_two && run_code == ST_SAME) ? ST_TWO_LONGER : run_code);
      return;
    end
    if (!p.has_two) begin
      close_comparison((run_code == ST_SAME) ? ST_ONE_LONGER : run_code);
      return;
    end
    // only matched newlines count as lines
    if (p.one == p.two) begin
      if (regs.count_lines && p.one == NEWLINE_BYTE) newlines = bump(newlines);
    end else begin
      if (!regs.silent) push_record(KIND_MISMATCH, ST_DIFFER, p.one, p.two);
      run_code = ST_DIFFER;
    end
    at_one = bump(at_one);
    at_two = bump(at_two);
    pairs  = bump(pairs);
    if (p.one != p.two && (regs.silent || !regs.report_all)) begin
      close_comparison(ST_DIFFER);
      return;
    end
    if (limit_hit()) close_comparison(run_code);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic bit rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic pair_t make_pair(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b,
                                      bit h1, bit h2, bit e1, bit e2);
    pair_t p;
    p.one     = a;
    p.two     = b;
    p.has_one = h1;
    p.has_two = h2;
    p.err_one = e1;
    p.err_two = e2;
    return p;
  endfunction

  // Offer one pair and hold it until the transaction completes
  task automatic send_pair(pair_t p);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.two, p.one};
    s_axis_tuser  <= {p.err_two, p.err_one, p.has_two, p.has_one};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    step_comparison(p);
  endtask

  // Drop the input and wait until every record is out and the block has settled
  task automatic wait_idle();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [FIELD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_START_POS_ONE: regs.start_one   = val;
      REG_START_POS_TWO: regs.start_two   = val;
      REG_COUNT_LIMIT:   regs.limit       = val;
      REG_SILENT_MODE:   regs.silent      = val[0];
      REG_REPORT_ALL:    regs.report_all  = val[0];
      REG_COUNT_LINES:   regs.count_lines = val[0];
      default: ;
    endcase
    restart_comparison();
  endtask

  task automatic program_regs(cfg_set_t c);
    wait_idle();
    write_reg(REG_START_POS_ONE, c.start_one);
    write_reg(REG_START_POS_TWO, c.start_two);
    write_reg(REG_COUNT_LIMIT, c.limit);
    write_reg(REG_SILENT_MODE, FIELD_W'(c.silent));
    write_reg(REG_REPORT_ALL, FIELD_W'(c.report_all));
    write_reg(REG_COUNT_LINES, FIELD_W'(c.count_lines));
    cfg_valid <= 1'b0;
    comparisons++;
  endtask

  // Rewrite one register with its current value, which restarts the comparison
  task automatic restart_with(cfg_reg_t idx);
    logic [FIELD_W-1:0] val;
    case (idx)
      REG_START_POS_ONE: val = regs.start_one;
      REG_START_POS_TWO: val = regs.start_two;
      REG_COUNT_LIMIT:   val = regs.limit;
      REG_SILENT_MODE:   val = FIELD_W'(regs.silent);
      REG_REPORT_ALL:    val = FIELD_W'(regs.report_all);
      default:           val = FIELD_W'(regs.count_lines);
    endcase
    wait_idle();
    write_reg(idx, val);
    cfg_valid <= 1'b0;
    comparisons++;
  endtask

  // ---------------------------------------------------------------------------
  // Record checking
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string name, logic [FIELD_W-1:0] want,
                                        logic [FIELD_W-1:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_record();
    record_t want;
    if (pending_records.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: record expected none actual kind %0b tdata %h", $time,
                 m_axis_tuser, m_axis_tdata);
      return;
    end
    want = pending_records.pop_front();
    if (want.kind == KIND_FINAL) final_records++;
    else mismatch_records++;
    compare_field("record_kind", FIELD_W'(want.kind), FIELD_W'(m_axis_tuser));
    compare_field("status", FIELD_W'(want.status), FIELD_W'(m_axis_tdata[2:0]));
    compare_field("position_one", want.pos_one, m_axis_tdata[50:3]);
    compare_field("position_two", want.pos_two, m_axis_tdata[98:51]);
    compare_field("line_number", want.line, m_axis_tdata[146:99]);
    compare_field("mismatch_one", FIELD_W'(want.byte_one), FIELD_W'(m_axis_tdata[154:147]));
    compare_field("mismatch_two", FIELD_W'(want.byte_two), FIELD_W'(m_axis_tdata[162:155]));
    compare_field("pad", '0, FIELD_W'(m_axis_tdata[OUT_DATA_W-1:163]));
    compare_field("last", FIELD_W'(want.last), FIELD_W'(m_axis_tlast));
  endfunction

  // Receiver: random stalls, an occasional long hold, check every transaction
  initial begin : record_receiver
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (recv_hold > 0) begin
        stall = recv_hold;
        recv_hold = 0;
      end else begin
        stall = $urandom_range(0, recv_gap_max);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      check_record();
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  function automatic cfg_set_t plain_settings();
    cfg_set_t c;
    c = '0;
    return c;
  endfunction

  function automatic logic [FIELD_W-1:0] rand_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[FIELD_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] pick_start();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return FIELD_W'($urandom_range(0, 1000));
      2:       return POS_MAX - FIELD_W'($urandom_range(0, 8));
      default: return rand_word();
    endcase
  endfunction

  // Comparison straight out of reset with every register at zero
  task automatic test_reset_defaults();
    send_pair(make_pair(8'h41, 8'h41, 1'b1, 1'b1, 1'b0, 1'b0));
    send_pair(make_pair(NEWLINE_BYTE, NEWLINE_BYTE, 1'b1, 1'b1, 1'b0, 1'b0));
    send_pair(make_pair(8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_mismatch_modes();
    cfg_set_t c;
    // report every difference while counting lines
    c = plain_settings();
    c.report_all  = 1'b1;
    c.count_lines = 1'b1;
    program_regs(c);
    send_pair(make_pair(NEWLINE_BYTE, NEWLINE_BYTE, 1'b1, 1'b1, 1'b0, 1'b0));
    send_pair(make_pair(8'h00, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0));
    send_pair(make_pair(NEWLINE_BYTE, 8'h0B, 1'b1, 1'b1, 1'b0, 1'b0));
    send_pair(make_pair(NEWLINE_BYTE, NEWLINE_BYTE, 1'b1, 1'b1, 1'b0, 1'b0));
    send_pair(make_pair(8'h55, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
    // silent overrides report-all; the pair after the end is dropped
    c = plain_settings();
    c.silent     = 1'b1;
    c.report_all = 1'b1;
    program_regs(c);
    send_pair(make_pair(8'hFF, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
    send_pair(make_pair(8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0));
    // first difference stops the comparison with both records
    c = plain_settings();
    c.limit = POS_MAX;
    program_regs(c);
    send_pair(make_pair(8'h01, 8'h02, 1'b1, 1'b1, 1'b0, 1'b0));
  endtask

  task automatic test_saturation_and_limit();
    cfg_set_t c;
    c = plain_settings();
    c.start_one   = POS_MAX - 1'b1;
    c.start_two   = POS_MAX;
    c.limit       = FIELD_W'(3);
    c.count_lines = 1'b1;
    program_regs(c);
    repeat (3) send_pair(make_pair(NEWLINE_BYTE, NEWLINE_BYTE, 1'b1, 1'b1, 1'b0, 1'b0));
  endtask

  task automatic test_stream_ends();
    program_regs(plain_settings());
    send_pair(make_pair(8'hA5, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b0));
    restart_with(REG_COUNT_LINES);
    send_pair(make_pair(8'h5A, 8'hA5, 1'b1, 1'b0, 1'b0, 1'b0));
    restart_with(REG_SILENT_MODE);
    send_pair(make_pair(8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_errors();
    restart_with(REG_START_POS_ONE);
    send_pair(make_pair(8'h12, 8'h12, 1'b1, 1'b1, 1'b1, 1'b1));
    restart_with(REG_START_POS_TWO);
    send_pair(make_pair(8'h34, 8'h34, 1'b1, 1'b1, 1'b0, 1'b1));
    restart_with(REG_COUNT_LIMIT);
    send_pair(make_pair(8'h00, 8'h77, 1'b0, 1'b1, 1'b0, 1'b1));
  endtask

  // Hold the output off while the sender keeps pushing mismatches
  task automatic test_output_stall();
    cfg_set_t c;
    int i;
    c = plain_settings();
    c.report_all  = 1'b1;
    c.count_lines = 1'b1;
    program_regs(c);
    send_gap_max = 0;
    recv_hold = 200;
    for (i = 0; i < 40; i++) begin
      if (i % 2 == 0) send_pair(make_pair(8'hC3, 8'h3C, 1'b1, 1'b1, 1'b0, 1'b0));
      else send_pair(make_pair(NEWLINE_BYTE, NEWLINE_BYTE, 1'b1, 1'b1, 1'b0, 1'b0));
    end
    send_pair(make_pair(8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    send_gap_max = 5;
  endtask

  task automatic test_random_streams();
    cfg_set_t c;
    pair_t p;
    int target;
    int len;
    int n;
    int roll;
    int diff_pct;
    logic [BYTE_W-1:0] b;
    target = compared_items + RANDOM_ITEMS;
    while (compared_items < target) begin
      // pick a setting or just restart the current one
      if ($urandom_range(0, 4) == 0) begin
        restart_with(cfg_reg_t'(3'($urandom_range(0, 5))));
      end else begin
        c.start_one   = pick_start();
        c.start_two   = pick_start();
        case ($urandom_range(0, 3))
          0:       c.limit = '0;
          1:       c.limit = FIELD_W'($urandom_range(1, 12));
          2:       c.limit = POS_MAX;
          default: c.limit = rand_word();
        endcase
        c.silent      = ($urandom_range(0, 4) == 0);
        c.report_all  = rand_bit();
        c.count_lines = rand_bit();
        program_regs(c);
      end
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      diff_pct = (regs.report_all && !regs.silent) ? 25 : 5;
      len = $urandom_range(1, 40);
      // mostly well-formed pairs, with some noise
      for (n = 0; n < len && !cmp_done; n++) begin
        roll = $urandom_range(0, 99);
        b = ($urandom_range(0, 2) == 0) ? NEWLINE_BYTE : rand_byte();
        if (roll < 4) begin
          p = make_pair(rand_byte(), rand_byte(), rand_bit(), rand_bit(),
                        rand_bit(), rand_bit());
        end else if (roll < 4 + diff_pct) begin
          p = make_pair(b, b ^ 8'($urandom_range(1, 255)), 1'b1, 1'b1, 1'b0, 1'b0);
        end else begin
          p = make_pair(b, b, 1'b1, 1'b1, 1'b0, 1'b0);
        end
        send_pair(p);
      end
      // close the comparison one way or another
      if (!cmp_done) begin
        case ($urandom_range(0, 4))
          0:       p = make_pair(8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
          1:       p = make_pair(rand_byte(), 8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
          2:       p = make_pair(8'h00, rand_byte(), 1'b0, 1'b1, 1'b0, 1'b0);
          3:       p = make_pair(rand_byte(), rand_byte(), 1'b1, 1'b1,
                                 1'b1, rand_bit());
          default: p = make_pair(rand_byte(), rand_byte(),
                                 rand_bit(), rand_bit(), 1'b0, 1'b1);
        endcase
        send_pair(p);
      end
      // up to two pairs after the end, which the block drops
      repeat ($urandom_range(0, 2))
        send_pair(make_pair(rand_byte(), rand_byte(), rand_bit(), rand_bit(),
                            rand_bit(), rand_bit()));
    end
    send_gap_max = 5;
    recv_gap_max = 5;
  endtask

  initial begin : main_sequence
    regs = plain_settings();
    restart_comparison();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_mismatch_modes();
    test_saturation_and_limit();
    test_stream_ends();
    test_errors();
    test_output_stall();
    test_random_streams();
    wait_idle();
    repeat (20) @(posedge clk);
    $display("Compared %0d byte pairs in %0d comparisons, %0d pairs dropped after the end",
             compared_items, comparisons, ignored_items);
    $display("Checked %0d mismatch records and %0d final records",
             mismatch_records, final_records);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
